FILE: design/sfr_pkg.sv
// Shared types, constants and the CRC-8 step for the stuffed frame receiver.
package sfr_pkg;

    localparam int FRAME_BYTES_DEF = 32;

    localparam logic [7:0] ESC_BYTE  = 8'hDC;
    localparam logic [7:0] ESC_FLIP  = 8'h80;
    localparam logic [7:0] TERM_BYTE = 8'h0A;
    localparam int         MIN_STORED = 5;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ON   = 1'b1;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_OVERFLOW  = 3'd1;
    localparam logic [2:0] STAT_SHORT     = 3'd2;
    localparam logic [2:0] STAT_CRC       = 3'd3;
    localparam logic [2:0] STAT_ADDRESS   = 3'd4;

    // classified word passed from front to back
    typedef struct packed {
        logic       is_term;
        logic [7:0] value;
    } item_t;

    typedef struct packed {
        logic [7:0] own_address;
        logic       filter_on;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [4:0] byte_index;
        logic       has_data;
        logic [2:0] frame_status;
        logic       last;
    } result_t;

    // CRC-8, polynomial 0x07, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ 8'h07;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

FILE: design/sfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/sfr_front.sv
// Front end: removes byte stuffing and classifies each word as data or terminator.
module sfr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_data,
    output logic          push_valid,
    input  logic          push_ready,
    output sfr_pkg::item_t push_item
);

    import sfr_pkg::*;

    logic esc_reg;
    logic esc_next;
    logic is_esc;

    assign in_ready = push_ready;
    assign is_esc   = !esc_reg && (in_data == ESC_BYTE);

    always_comb
    begin
        push_valid        = in_valid && !is_esc;
        push_item.is_term = !esc_reg && (in_data == TERM_BYTE);
        push_item.value   = esc_reg ? (in_data ^ ESC_FLIP) : in_data;
        esc_next          = esc_reg;
        if (in_valid && push_ready)
        begin
            esc_next = is_esc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= 1'b0;
        end
        else
        begin
            esc_reg <= esc_next;
        end
    end

endmodule

FILE: design/sfr_queue.sv
// Two-entry queue of classified words between front and back.
module sfr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  sfr_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output sfr_pkg::item_t pop_item
);

    import sfr_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: design/sfr_back.sv
// Back end: frame store, CRC, terminator checks and result emission.
module sfr_back #(
    parameter int FRAME_BYTES = sfr_pkg::FRAME_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  sfr_pkg::item_t   pop_item,
    input  sfr_pkg::cfg_t    cfg,
    output logic             out_valid,
    input  logic             out_ready,
    output sfr_pkg::result_t out_result
);

    import sfr_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(FRAME_BYTES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STATUS,
        ST_EMIT
    } state_t;

    state_t        state_reg,     state_next;
    logic [CW-1:0] count_reg,     count_next;
    logic [7:0]    crc_reg,       crc_next;
    logic          discard_reg,   discard_next;
    logic [7:0]    byte1_reg,     byte1_next;
    logic [2:0]    status_reg,    status_next;
    logic [AW-1:0] idx_reg,       idx_next;
    logic [AW-1:0] last_idx_reg,  last_idx_next;
    logic          rd_ok_reg,     rd_ok_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg,       out_next;

    logic          ram_we;
    logic [7:0]    ram_rdata;
    logic          out_free;
    logic          take;
    logic [2:0]    term_status;

    assign pop_ready  = (state_reg == ST_IDLE);
    assign take       = pop_valid && pop_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    sfr_ram #(
        .WIDTH(8),
        .DEPTH(FRAME_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (pop_item.value),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (discard_reg)
        begin
            term_status = STAT_OVERFLOW;
        end
        else if (count_reg < CW'(MIN_STORED))
        begin
            term_status = STAT_SHORT;
        end
        else if (crc_reg != 8'h00)
        begin
            term_status = STAT_CRC;
        end
        else if (cfg.filter_on && (byte1_reg != cfg.own_address))
        begin
            term_status = STAT_ADDRESS;
        end
        else
        begin
            term_status = STAT_OK;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        crc_next       = crc_reg;
        discard_next   = discard_reg;
        byte1_next     = byte1_reg;
        status_next    = status_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        rd_ok_next     = 1'b1;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        ram_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (take && !pop_item.is_term && !discard_reg)
                begin
                    if (count_reg == CW'(FRAME_BYTES))
                    begin
                        discard_next = 1'b1;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        crc_next   = crc8_step(crc_reg, pop_item.value);
                        if (count_reg == CW'(1))
                        begin
                            byte1_next = pop_item.value;
                        end
                    end
                end
                else if (take && pop_item.is_term)
                begin
                    count_next    = '0;
                    crc_next      = 8'h00;
                    discard_next  = 1'b0;
                    status_next   = term_status;
                    idx_next      = '0;
                    last_idx_next = AW'(count_reg - CW'(2));
                    rd_ok_next    = 1'b0;
                    state_next    = (term_status == STAT_OK) ? ST_EMIT : ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.data_byte      = 8'h00;
                    out_next.byte_index     = 5'd0;
                    out_next.has_data       = 1'b0;
                    out_next.frame_status   = status_reg;
                    out_next.last           = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (rd_ok_reg && out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.data_byte      = ram_rdata;
                    out_next.byte_index     = 5'(idx_reg);
                    out_next.has_data       = 1'b1;
                    out_next.frame_status   = STAT_OK;
                    out_next.last           = (idx_reg == last_idx_reg);
                    idx_next                = idx_reg + AW'(1);
                    rd_ok_next              = 1'b0;
                    if (idx_reg == last_idx_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            crc_reg       <= 8'h00;
            discard_reg   <= 1'b0;
            byte1_reg     <= 8'h00;
            status_reg    <= STAT_OK;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            discard_reg   <= discard_next;
            byte1_reg     <= byte1_next;
            status_reg    <= status_next;
            idx_reg       <= idx_next;
            last_idx_reg  <= last_idx_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

FILE: design/stuffed_frame_receiver_crc8.sv
// Top level of the byte-stuffed frame receiver with CRC-8 check.
// Raw line bytes are taken at one word per cycle while the two-entry queue
// has room; an escape byte (0xDC) flips bit 7 of the next byte and a plain
// newline ends the frame. Each data byte is written to the store and
// updates the CRC. At a newline the frame is checked; a bad frame gives
// one status word, a good one replays its stored bytes without the CRC,
// each through a store read and then the output register, the next byte
// being read only after the previous one is registered for output. The
// output register lets the back end run ahead by one word under stall.
// The store holds FRAME_BYTES bytes; more bytes mark the frame as overflowed
// and are dropped up to the newline. Configuration takes effect at the next
// newline and is always accepted.
module stuffed_frame_receiver_crc8 #(
    parameter int FRAME_BYTES = sfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [7:0] data_byte, [12:8] byte_index
    output logic [3:0]                    m_axis_tuser,   // [0] has_data, [3:1] frame_status
    output logic                          m_axis_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);

    import sfr_pkg::*;

    cfg_t    cfg_reg;
    logic    push_valid;
    logic    push_ready;
    item_t   push_item;
    logic    pop_valid;
    logic    pop_ready;
    item_t   pop_item;
    result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address <= 8'h00;
            cfg_reg.filter_on   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OWN_ADDRESS: cfg_reg.own_address <= cfg_data;
                REG_FILTER_ON:   cfg_reg.filter_on   <= cfg_data[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    sfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    sfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    sfr_back #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .cfg        (cfg_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {3'b000, result.byte_index, result.data_byte};
    assign m_axis_tuser = {result.frame_status, result.has_data};
    assign m_axis_tlast = result.last;

endmodule

FILE: test/tb_stuffed_frame_receiver_crc8.sv
// Testbench for stuffed_frame_receiver_crc8: directed and random frames against a predictor.
module tb_stuffed_frame_receiver_crc8;

    import sfr_pkg::*;

    localparam int STORE_BYTES = FRAME_BYTES_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 40;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;
    logic [3:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    // expected output words, oldest first
    result_t    expected_words[$];
    logic [7:0] frame_buf[$];

    // predictor state
    logic [7:0] rx_store[STORE_BYTES];
    int         rx_count;
    logic [7:0] rx_crc;
    logic       rx_escaped;
    logic       rx_dropping;
    logic [7:0] own_addr;
    logic       filter_on;

    int errors;
    int sent_words;
    int stall_cycles = 0;
    int src_idle;
    int dst_idle;
    int esc_pct;

    stuffed_frame_receiver_crc8 u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // serial form of CRC-8, poly 0x07
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[7] ^ d[i];
            r = {r[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
        end
        return r;
    endfunction

    function automatic void restart_frame();
        rx_count = 0;
        rx_crc = 8'h00;
        rx_dropping = 1'b0;
    endfunction

    function automatic void push_status(input logic [2:0] st);
        result_t w;
        w = '0;
        w.frame_status = st;
        w.last = 1'b1;
        expected_words.push_back(w);
    endfunction

    // destuff one line byte and queue the words it releases
    function automatic void deframe_byte(input logic [7:0] raw);
        logic [7:0] c;
        result_t    w;
        c = raw;
        if (rx_escaped)
        begin
            rx_escaped = 1'b0;
            c = c ^ ESC_FLIP;
        end
        else if (c == ESC_BYTE)
        begin
            rx_escaped = 1'b1;
            return;
        end
        else if (c == TERM_BYTE)
        begin
            if (rx_dropping)
                push_status(STAT_OVERFLOW);
            else if (rx_count < MIN_STORED)
                push_status(STAT_SHORT);
            else if (rx_crc != 8'h00)
                push_status(STAT_CRC);
            else if (filter_on && rx_store[1] != own_addr)
                push_status(STAT_ADDRESS);
            else
            begin
                for (int i = 0; i < rx_count - 1; i++)
                begin
                    w.data_byte = rx_store[i];
                    w.byte_index = i[4:0];
                    w.has_data = 1'b1;
                    w.frame_status = STAT_OK;
                    w.last = (i == rx_count - 2);
                    expected_words.push_back(w);
                end
            end
            restart_frame();
            return;
        end
        if (rx_dropping)
            return;
        if (rx_count >= STORE_BYTES)
        begin
            rx_dropping = 1'b1;
            return;
        end
        rx_store[rx_count] = c;
        rx_count++;
        rx_crc = crc8_next(rx_crc, c);
    endfunction

    task automatic send_word(input logic [7:0] b);
        if ($urandom_range(0, 99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < src_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge clk); while (!s_axis_tready);
        sent_words++;
        deframe_byte(b);
    endtask

    // payload of n bytes with byte 1 = addr, CRC appended
    task automatic make_frame(input int n, input logic [7:0] addr, input bit bad_crc);
        logic [7:0] crc;
        logic [7:0] d;
        frame_buf.delete();
        crc = 8'h00;
        for (int i = 0; i < n; i++)
        begin
            d = (i == 1) ? addr : 8'($urandom_range(0, 255));
            frame_buf.push_back(d);
            crc = crc8_next(crc, d);
        end
        if (bad_crc)
            crc = crc ^ (8'h01 << $urandom_range(0, 7));
        frame_buf.push_back(crc);
    endtask

    task automatic fill_random(input int n);
        frame_buf.delete();
        for (int i = 0; i < n; i++)
            frame_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // stuff frame_buf onto the line and terminate it
    task automatic send_frame();
        foreach (frame_buf[i])
        begin
            if (frame_buf[i] == ESC_BYTE || frame_buf[i] == TERM_BYTE
                || frame_buf[i] == (TERM_BYTE ^ ESC_FLIP)
                || frame_buf[i] == (ESC_BYTE ^ ESC_FLIP)
                || $urandom_range(0, 99) < esc_pct)
            begin
                send_word(ESC_BYTE);
                send_word(frame_buf[i] ^ ESC_FLIP);
            end
            else
                send_word(frame_buf[i]);
        end
        send_word(TERM_BYTE);
    endtask

    task automatic flush_line();
        if (rx_escaped)
            send_word(8'h00);
        send_word(TERM_BYTE);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_OWN_ADDRESS)
            own_addr = value;
        else
            filter_on = value[0];
    endtask

    task automatic test_short_frames();
        send_word(TERM_BYTE);
        fill_random(4);
        send_frame();
        make_frame(3, own_addr, 1'b0);
        send_frame();
    endtask

    task automatic test_good_frames();
        frame_buf = '{8'h00, own_addr, 8'hFF, 8'h00};
        frame_buf.push_back(8'h00);
        for (int i = 0; i < 4; i++)
            frame_buf[4] = crc8_next(frame_buf[4], frame_buf[i]);
        send_frame();
        // escaped newline, double escape, and stuffed specials in one frame
        frame_buf = '{8'h8A, own_addr, 8'h5C, TERM_BYTE, ESC_BYTE, 8'hFF};
        frame_buf.push_back(8'h00);
        for (int i = 0; i < 6; i++)
            frame_buf[6] = crc8_next(frame_buf[6], frame_buf[i]);
        send_frame();
    endtask

    task automatic test_crc_error();
        make_frame(4, own_addr, 1'b1);
        send_frame();
    endtask

    task automatic test_address_filter();
        make_frame(5, own_addr ^ 8'h55, 1'b0);
        send_frame();
        make_frame(4, own_addr ^ 8'h01, 1'b1);
        send_frame();
    endtask

    task automatic test_overflow();
        make_frame(STORE_BYTES - 1, own_addr, 1'b0);
        send_frame();
        make_frame(STORE_BYTES, own_addr, 1'b0);
        send_frame();
        make_frame(STORE_BYTES + 4, own_addr, 1'b0);
        frame_buf[STORE_BYTES + 1] = TERM_BYTE ^ ESC_FLIP;
        frame_buf[STORE_BYTES + 2] = ESC_BYTE ^ ESC_FLIP;
        send_frame();
        make_frame(4, own_addr, 1'b0);
        send_frame();
    endtask

    task automatic test_config_regs();
        set_register(REG_OWN_ADDRESS, 8'hFF);
        make_frame(5, 8'hFF, 1'b0);
        send_frame();
        make_frame(5, 8'h00, 1'b0);
        send_frame();
        set_register(REG_FILTER_ON, 8'h00);
        make_frame(5, 8'h00, 1'b0);
        send_frame();
        set_register(REG_FILTER_ON, 8'h01);
        set_register(REG_OWN_ADDRESS, 8'h00);
    endtask

    task automatic test_random(input int n_words);
        int start;
        int pick;
        int k;
        logic [7:0] addr;
        start = sent_words;
        while (sent_words - start < n_words)
        begin
            pick = $urandom_range(0, 99);
            addr = (filter_on || $urandom_range(0, 1)) ? own_addr : 8'($urandom_range(0, 255));
            if (pick < 65)
            begin
                k = ($urandom_range(0, 19) == 0) ? STORE_BYTES - 1 : $urandom_range(4, 10);
                make_frame(k, addr, 1'b0);
                send_frame();
            end
            else if (pick < 73)
            begin
                make_frame($urandom_range(4, 10), addr, 1'b1);
                send_frame();
            end
            else if (pick < 80)
            begin
                make_frame($urandom_range(4, 10), ~addr, 1'b0);
                send_frame();
            end
            else if (pick < 86)
            begin
                fill_random($urandom_range(0, 4));
                send_frame();
            end
            else if (pick < 89)
            begin
                make_frame($urandom_range(STORE_BYTES, STORE_BYTES + 3), addr, 1'b0);
                send_frame();
            end
            else
            begin
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++)
                begin
                    case ($urandom_range(0, 3))
                        0: send_word(ESC_BYTE);
                        1: send_word(TERM_BYTE);
                        default: send_word(8'($urandom_range(0, 255)));
                    endcase
                end
                if ($urandom_range(0, 1))
                    flush_line();
            end
        end
        flush_line();
    endtask

    // receiver stall
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= dst_idle);
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t exp;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.data_byte = m_axis_tdata[7:0];
            got.byte_index = m_axis_tdata[12:8];
            got.has_data = m_axis_tuser[0];
            got.frame_status = m_axis_tuser[3:1];
            got.last = m_axis_tlast;
            if (expected_words.size() == 0)
            begin
                if (errors < 10)
                    $display("ERROR: unexpected word data=%h idx=%0d has=%b st=%0d last=%b",
                             got.data_byte, got.byte_index, got.has_data,
                             got.frame_status, got.last);
                errors++;
            end
            else
            begin
                exp = expected_words.pop_front();
                if (got.data_byte !== exp.data_byte || got.byte_index !== exp.byte_index
                    || got.has_data !== exp.has_data || got.frame_status !== exp.frame_status
                    || got.last !== exp.last)
                begin
                    if (errors < 10)
                        $display("ERROR: data/idx/has/st/last exp %h/%0d/%b/%0d/%b got %h/%0d/%b/%0d/%b",
                                 exp.data_byte, exp.byte_index, exp.has_data, exp.frame_status,
                                 exp.last, got.data_byte, got.byte_index, got.has_data,
                                 got.frame_status, got.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("stuffed_frame_receiver_crc8: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= 8'h00;
        errors = 0;
        sent_words = 0;
        esc_pct = 5;
        src_idle = 29;
        dst_idle = 63;
        restart_frame();
        rx_escaped = 1'b0;
        own_addr = 8'h00;
        filter_on = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_frames();
        test_good_frames();
        test_crc_error();
        test_address_filter();
        test_overflow();
        test_config_regs();

        set_register(REG_OWN_ADDRESS, 8'($urandom_range(1, 254)));
        test_random(15);

        src_idle = 63;
        dst_idle = 29;
        set_register(REG_OWN_ADDRESS, 8'hFF);
        set_register(REG_FILTER_ON, 8'h00);
        test_random(15);

        src_idle = 0;
        dst_idle = 0;
        set_register(REG_OWN_ADDRESS, 8'h00);
        set_register(REG_FILTER_ON, 8'h01);
        test_random(15);

        wait_idle();
        errors += expected_words.size();
        if (errors == 0)
            $display("stuffed_frame_receiver_crc8: match");
        else
            $display("stuffed_frame_receiver_crc8: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
design/sfr_pkg.sv
design/sfr_ram.sv
design/sfr_front.sv
design/sfr_queue.sv
design/sfr_back.sv
design/stuffed_frame_receiver_crc8.sv
test/tb_stuffed_frame_receiver_crc8.sv
